### hdl/qapm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_pkg
// shared types, register indexes, reset values and the square root steps
// ----------------------------------------------------------------------------
package qapm_pkg;

    // configuration port
    localparam int CfgIndexW = 4;
    localparam int CfgDataW  = 32;

    localparam logic [CfgIndexW-1:0] RegRollPropGain   = 4'd0;
    localparam logic [CfgIndexW-1:0] RegPitchPropGain  = 4'd1;
    localparam logic [CfgIndexW-1:0] RegRollDerivGain  = 4'd2;
    localparam logic [CfgIndexW-1:0] RegPitchDerivGain = 4'd3;
    localparam logic [CfgIndexW-1:0] RegYawRateGain    = 4'd4;
    localparam logic [CfgIndexW-1:0] RegThrustCoefRcp  = 4'd5;
    localparam logic [CfgIndexW-1:0] RegArmMomentRcp   = 4'd6;
    localparam logic [CfgIndexW-1:0] RegYawMomentRcp   = 4'd7;

    localparam logic [15:0] RstRollPropGain   = 16'd256;
    localparam logic [15:0] RstPitchPropGain  = 16'd256;
    localparam logic [15:0] RstRollDerivGain  = 16'd64;
    localparam logic [15:0] RstPitchDerivGain = 16'd64;
    localparam logic [15:0] RstYawRateGain    = 16'd64;
    localparam logic [31:0] RstThrustCoefRcp  = 32'd25600000;
    localparam logic [31:0] RstArmMomentRcp   = 32'd36200000;
    localparam logic [31:0] RstYawMomentRcp   = 32'd256000000;

    // pipeline shape
    localparam int NumStages       = 8;
    localparam int NumRotors       = 4;
    localparam int SqrtStepsPerStg = 4;

    // restoring square root state: radicand bits still to consume,
    // partial remainder and partial root
    typedef struct packed {
        logic [31:0] x;
        logic [17:0] rem;
        logic [15:0] root;
    } t_sqrt;

    typedef logic [15:0] t_speed;

    function automatic t_sqrt sqrt_steps(input t_sqrt a);
        t_sqrt       s;
        logic [19:0] trial;
        logic [19:0] sub;
        s = a;
        for (int i = 0; i < SqrtStepsPerStg; i++) begin
            trial = {s.rem, s.x[31:30]};
            sub   = {2'b00, s.root, 2'b01};
            if (trial >= sub) begin
                s.rem  = 18'(trial - sub);
                s.root = {s.root[14:0], 1'b1};
            end else begin
                s.rem  = trial[17:0];
                s.root = {s.root[14:0], 1'b0};
            end
            s.x = {s.x[29:0], 2'b00};
        end
        return s;
    endfunction

endpackage

### hdl/qapm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_in_if
// input channel: one vehicle's setpoints and measured attitude per beat
// ----------------------------------------------------------------------------
interface qapm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] yaw_rate_target;
    logic signed [15:0] roll_target;
    logic signed [15:0] pitch_target;
    logic        [15:0] thrust_target;
    logic signed [15:0] roll_meas;
    logic signed [15:0] pitch_meas;
    logic signed [15:0] rate_p;
    logic signed [15:0] rate_q;
    logic signed [15:0] rate_r;

    modport source (
        output valid, yaw_rate_target, roll_target, pitch_target, thrust_target,
               roll_meas, pitch_meas, rate_p, rate_q, rate_r,
        input  ready
    );
    modport sink (
        input  valid, yaw_rate_target, roll_target, pitch_target, thrust_target,
               roll_meas, pitch_meas, rate_p, rate_q, rate_r,
        output ready
    );
endinterface

### hdl/qapm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_out_if
// output channel: four rotor speed commands per beat
// ----------------------------------------------------------------------------
interface qapm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] rotor0_speed;
    logic [15:0] rotor1_speed;
    logic [15:0] rotor2_speed;
    logic [15:0] rotor3_speed;

    modport source (
        output valid, rotor0_speed, rotor1_speed, rotor2_speed, rotor3_speed,
        input  ready
    );
    modport sink (
        input  valid, rotor0_speed, rotor1_speed, rotor2_speed, rotor3_speed,
        output ready
    );
endinterface

### hdl/quad_attitude_pd_rotor_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_attitude_pd_rotor_mixer
// attitude pd moments, x-quad mixer and integer square root to rotor speeds
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          beat contents
//  -------  ---  -----------------  ------------------------------------------
//  i_in     in   valid / ready      setpoints, measured angles, body rates
//  o_out    out  valid / ready      rotor0..rotor3 speed, unsigned q12.4
//  i_cfg_*  in   write enable only  register index, 32 bit write data
//
//  one beat in per cycle unless the output stalls, one beat out per beat in;
//  the stages hold the gain multipliers, the reciprocal multipliers, the
//  mixer adders and the 16-step square root, four stages of four steps each
//  each stage holds its own valid bit and loads whenever it is empty or the
//  stage after it moves, so bubbles collapse and a stall loses nothing
//  reset (synchronous, active low) empties the pipeline and loads the
//  register defaults; datapath registers are not reset
//
module quad_attitude_pd_rotor_mixer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    qapm_in_if.sink                         i_in,
    qapm_out_if.source                      o_out,
    input  logic                            i_cfg_wr_en,
    input  logic [qapm_pkg::CfgIndexW-1:0]  i_cfg_index,
    input  logic [qapm_pkg::CfgDataW-1:0]   i_cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_roll_prop_gain;
    logic [15:0] r_pitch_prop_gain;
    logic [15:0] r_roll_deriv_gain;
    logic [15:0] r_pitch_deriv_gain;
    logic [15:0] r_yaw_rate_gain;
    logic [31:0] r_thrust_coef_recip;
    logic [31:0] r_arm_moment_recip;
    logic [31:0] r_yaw_moment_recip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_prop_gain    <= qapm_pkg::RstRollPropGain;
            r_pitch_prop_gain   <= qapm_pkg::RstPitchPropGain;
            r_roll_deriv_gain   <= qapm_pkg::RstRollDerivGain;
            r_pitch_deriv_gain  <= qapm_pkg::RstPitchDerivGain;
            r_yaw_rate_gain     <= qapm_pkg::RstYawRateGain;
            r_thrust_coef_recip <= qapm_pkg::RstThrustCoefRcp;
            r_arm_moment_recip  <= qapm_pkg::RstArmMomentRcp;
            r_yaw_moment_recip  <= qapm_pkg::RstYawMomentRcp;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                qapm_pkg::RegRollPropGain:   r_roll_prop_gain    <= i_cfg_data[15:0];
                qapm_pkg::RegPitchPropGain:  r_pitch_prop_gain   <= i_cfg_data[15:0];
                qapm_pkg::RegRollDerivGain:  r_roll_deriv_gain   <= i_cfg_data[15:0];
                qapm_pkg::RegPitchDerivGain: r_pitch_deriv_gain  <= i_cfg_data[15:0];
                qapm_pkg::RegYawRateGain:    r_yaw_rate_gain     <= i_cfg_data[15:0];
                qapm_pkg::RegThrustCoefRcp:  r_thrust_coef_recip <= i_cfg_data;
                qapm_pkg::RegArmMomentRcp:   r_arm_moment_recip  <= i_cfg_data;
                qapm_pkg::RegYawMomentRcp:   r_yaw_moment_recip  <= i_cfg_data;
                default: ; // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow control: a stage moves when empty or when the next moves
    // ------------------------------------------------------------------
    logic [qapm_pkg::NumStages-1:0] r_v;
    logic [qapm_pkg::NumStages-1:0] w_adv;

    always_comb begin
        w_adv[qapm_pkg::NumStages-1] = !r_v[qapm_pkg::NumStages-1] || o_out.ready;
        for (int k = qapm_pkg::NumStages - 2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign i_in.ready  = w_adv[0];
    assign o_out.valid = r_v[qapm_pkg::NumStages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < qapm_pkg::NumStages; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: angle and rate errors times gains (q.19)
    // ------------------------------------------------------------------
    logic signed [16:0] w_roll_err;
    logic signed [16:0] w_pitch_err;
    logic signed [16:0] w_yaw_err;
    logic signed [32:0] w_roll_prop;
    logic signed [32:0] w_pitch_prop;
    logic signed [32:0] w_yaw_prop;
    logic signed [31:0] w_roll_deriv;
    logic signed [31:0] w_pitch_deriv;

    assign w_roll_err  = 17'(i_in.roll_target) - 17'(i_in.roll_meas);
    assign w_pitch_err = 17'(i_in.pitch_target) - 17'(i_in.pitch_meas);
    assign w_yaw_err   = 17'(i_in.yaw_rate_target) - 17'(i_in.rate_r);

    // gains are unsigned: widen with a zero so the product stays signed
    assign w_roll_prop   = 33'($signed({1'b0, r_roll_prop_gain}) * w_roll_err);
    assign w_pitch_prop  = 33'($signed({1'b0, r_pitch_prop_gain}) * w_pitch_err);
    assign w_yaw_prop    = 33'($signed({1'b0, r_yaw_rate_gain}) * w_yaw_err);
    assign w_roll_deriv  = 32'($signed({1'b0, r_roll_deriv_gain}) * i_in.rate_p);
    assign w_pitch_deriv = 32'($signed({1'b0, r_pitch_deriv_gain}) * i_in.rate_q);

    logic signed [32:0] r_roll_prop0;
    logic signed [32:0] r_pitch_prop0;
    logic signed [32:0] r_yaw_prop0;
    logic signed [31:0] r_roll_deriv0;
    logic signed [31:0] r_pitch_deriv0;
    logic        [15:0] r_thrust0;

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_roll_prop0   <= w_roll_prop;
            r_pitch_prop0  <= w_pitch_prop;
            r_yaw_prop0    <= w_yaw_prop;
            r_roll_deriv0  <= w_roll_deriv;
            r_pitch_deriv0 <= w_pitch_deriv;
            r_thrust0      <= i_in.thrust_target;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: p minus d, floor shift to q.16
    // ------------------------------------------------------------------
    logic signed [33:0] w_mx_full;
    logic signed [33:0] w_my_full;

    assign w_mx_full = 34'(r_roll_prop0) - 34'(r_roll_deriv0);
    assign w_my_full = 34'(r_pitch_prop0) - 34'(r_pitch_deriv0);

    logic signed [30:0] r_mx1;
    logic signed [30:0] r_my1;
    logic signed [30:0] r_mz1;
    logic        [15:0] r_thrust1;

    // dropping low bits of a two's complement value floors toward minus infinity
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_mx1     <= w_mx_full[33:3];
            r_my1     <= w_my_full[33:3];
            r_mz1     <= {r_yaw_prop0[32], r_yaw_prop0[32:3]};
            r_thrust1 <= r_thrust0;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: moments times reciprocal coefficients, thrust term
    // ------------------------------------------------------------------
    logic signed [62:0] r_tx2;
    logic signed [62:0] r_ty2;
    logic signed [62:0] r_tz2;
    logic        [47:0] r_tt2;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_tx2 <= 63'(r_mx1 * $signed({1'b0, r_arm_moment_recip}));
            r_ty2 <= 63'(r_my1 * $signed({1'b0, r_arm_moment_recip}));
            r_tz2 <= 63'(r_mz1 * $signed({1'b0, r_yaw_moment_recip}));
            r_tt2 <= 48'(r_thrust1 * r_thrust_coef_recip);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: x-quad mix in q.16
    // ------------------------------------------------------------------
    logic signed [57:0] w_tx;
    logic signed [57:0] w_ty;
    logic signed [57:0] w_tz;
    logic signed [57:0] w_tt;

    // floor shift by 8, then sign extend to the mix width
    assign w_tx = {{3{r_tx2[62]}}, r_tx2[62:8]};
    assign w_ty = {{3{r_ty2[62]}}, r_ty2[62:8]};
    assign w_tz = {{3{r_tz2[62]}}, r_tz2[62:8]};
    assign w_tt = {10'd0, r_tt2};

    logic signed [57:0] r_mix3 [qapm_pkg::NumRotors];

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_mix3[0] <= w_tt - w_tx - w_ty - w_tz;
            r_mix3[1] <= w_tt + w_tx - w_ty + w_tz;
            r_mix3[2] <= w_tt + w_tx + w_ty - w_tz;
            r_mix3[3] <= w_tt - w_tx + w_ty + w_tz;
        end
    end

    // ------------------------------------------------------------------
    // stages 4..7: negative and overflow flags, square root of mix / 1024
    // a radicand at or above 2^32 always gives a root above the 16 bit range
    // ------------------------------------------------------------------
    qapm_pkg::t_sqrt w_sq_init [qapm_pkg::NumRotors];
    qapm_pkg::t_sqrt r_sq4 [qapm_pkg::NumRotors];
    qapm_pkg::t_sqrt r_sq5 [qapm_pkg::NumRotors];
    qapm_pkg::t_sqrt r_sq6 [qapm_pkg::NumRotors];
    logic [qapm_pkg::NumRotors-1:0] r_neg4, r_neg5, r_neg6;
    logic [qapm_pkg::NumRotors-1:0] r_sat4, r_sat5, r_sat6;
    qapm_pkg::t_speed r_speed7 [qapm_pkg::NumRotors];

    always_comb begin
        for (int n = 0; n < qapm_pkg::NumRotors; n++) begin
            w_sq_init[n].x    = r_mix3[n][41:10];
            w_sq_init[n].rem  = '0;
            w_sq_init[n].root = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int n = 0; n < qapm_pkg::NumRotors; n++) begin
            if (w_adv[4]) begin
                r_neg4[n] <= r_mix3[n][57];
                r_sat4[n] <= !r_mix3[n][57] && (|r_mix3[n][56:42]);
                r_sq4[n]  <= qapm_pkg::sqrt_steps(w_sq_init[n]);
            end
            if (w_adv[5]) begin
                r_neg5[n] <= r_neg4[n];
                r_sat5[n] <= r_sat4[n];
                r_sq5[n]  <= qapm_pkg::sqrt_steps(r_sq4[n]);
            end
            if (w_adv[6]) begin
                r_neg6[n] <= r_neg5[n];
                r_sat6[n] <= r_sat5[n];
                r_sq6[n]  <= qapm_pkg::sqrt_steps(r_sq5[n]);
            end
        end
    end

    // last four root bits, then clamp negatives and saturate overflow
    qapm_pkg::t_sqrt w_sq_last [qapm_pkg::NumRotors];

    always_comb begin
        for (int n = 0; n < qapm_pkg::NumRotors; n++) begin
            w_sq_last[n] = qapm_pkg::sqrt_steps(r_sq6[n]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int n = 0; n < qapm_pkg::NumRotors; n++) begin
            if (w_adv[7]) begin
                if (r_neg6[n]) begin
                    r_speed7[n] <= '0;
                end else if (r_sat6[n]) begin
                    r_speed7[n] <= '1;
                end else begin
                    r_speed7[n] <= w_sq_last[n].root;
                end
            end
        end
    end

    assign o_out.rotor0_speed = r_speed7[0];
    assign o_out.rotor1_speed = r_speed7[1];
    assign o_out.rotor2_speed = r_speed7[2];
    assign o_out.rotor3_speed = r_speed7[3];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // back-pressure reaches the input only when every stage holds a beat
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&r_v))
        else $error("input stalled while the pipeline has a bubble");

    // a taken output beat with nothing behind it leaves the output empty
    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !r_v[qapm_pkg::NumStages-2]) |=> !o_out.valid)
        else $error("output beat repeated");

    // a mix is never both negative and overflowing
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] |-> ((r_neg4 & r_sat4) == '0))
        else $error("rotor flagged negative and saturated at once");

    // reset empties the pipeline
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule

### dv/quad_attitude_pd_rotor_mixer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_attitude_pd_rotor_mixer_tb
// self-checking bench for the attitude pd controller and x-quad rotor mixer:
// vehicle beats go in over a valid/ready channel, every accepted beat is run
// through a bit-exact predictor of the moments, mixer and square root, and
// each rotor command beat is compared with the oldest prediction
// ----------------------------------------------------------------------------
module quad_attitude_pd_rotor_mixer_tb;

    localparam int NumRegs     = 8;
    localparam int LimitCycles = 500000;
    localparam int ReportCap   = 100;
    localparam int RandomItems = 1100;
    localparam int NumPhases   = 6;
    localparam int HoldOff     = 200;

    // one vehicle's setpoints and measurements, as carried by one input beat
    typedef struct {
        logic signed [15:0] yaw_rate_target;
        logic signed [15:0] roll_target;
        logic signed [15:0] pitch_target;
        logic        [15:0] thrust_target;
        logic signed [15:0] roll_meas;
        logic signed [15:0] pitch_meas;
        logic signed [15:0] rate_p;
        logic signed [15:0] rate_q;
        logic signed [15:0] rate_r;
    } t_vehicle;

    typedef struct {
        qapm_pkg::t_speed rotor [qapm_pkg::NumRotors];
    } t_rotor_cmd;

    // shadow copy of the configuration registers
    typedef struct {
        logic [15:0] roll_prop;
        logic [15:0] pitch_prop;
        logic [15:0] roll_deriv;
        logic [15:0] pitch_deriv;
        logic [15:0] yaw_rate;
        logic [31:0] thrust_rcp;
        logic [31:0] arm_rcp;
        logic [31:0] yaw_rcp;
    } t_gains;

    // receiver ready behavior
    typedef enum {RxAlways, RxRandom, RxPattern} t_rx_mode;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_wr_en;
    logic [qapm_pkg::CfgIndexW-1:0] cfg_index;
    logic [qapm_pkg::CfgDataW-1:0]  cfg_data;

    qapm_in_if  in_if ();
    qapm_out_if out_if ();

    quad_attitude_pd_rotor_mixer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    t_gains     gains;
    t_rotor_cmd pending_cmds [$];   // predicted rotor commands, oldest first
    int         n_fail    = 0;
    int         cycle_cnt = 0;
    t_rx_mode   rx_mode    = RxAlways;
    logic [15:0] rx_pattern = 16'hFFFF;
    int         rx_hold    = 0;     // cycles the receiver still holds off

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt == LimitCycles) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic t_gains reset_gains();
        t_gains g;
        g.roll_prop   = qapm_pkg::RstRollPropGain;
        g.pitch_prop  = qapm_pkg::RstPitchPropGain;
        g.roll_deriv  = qapm_pkg::RstRollDerivGain;
        g.pitch_deriv = qapm_pkg::RstPitchDerivGain;
        g.yaw_rate    = qapm_pkg::RstYawRateGain;
        g.thrust_rcp  = qapm_pkg::RstThrustCoefRcp;
        g.arm_rcp     = qapm_pkg::RstArmMomentRcp;
        g.yaw_rcp     = qapm_pkg::RstYawMomentRcp;
        return g;
    endfunction

    // bitwise restoring square root, floor of the true root
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem  = x;
        root = '0;
        b    = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // mix in q.16 -> speed q12.4: sqrt(mix / 1024), negatives give zero,
    // anything past the top of q12.4 saturates
    function automatic qapm_pkg::t_speed rotor_speed(input longint mix);
        logic [63:0] w;
        if (mix <= 0)
            return '0;
        w = floor_sqrt(64'(mix) >> 10);
        return (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic t_rotor_cmd predict_rotor_cmd(input t_vehicle v);
        longint     mx;
        longint     my;
        longint     mz;
        longint     tx;
        longint     ty;
        longint     tz;
        longint     tt;
        t_rotor_cmd c;
        // pd moments in q.19, errors are exact 17 bit values
        mx = longint'(gains.roll_prop) * (longint'(v.roll_target) - longint'(v.roll_meas))
           - longint'(gains.roll_deriv) * longint'(v.rate_p);
        my = longint'(gains.pitch_prop) * (longint'(v.pitch_target) - longint'(v.pitch_meas))
           - longint'(gains.pitch_deriv) * longint'(v.rate_q);
        mz = longint'(gains.yaw_rate) * (longint'(v.yaw_rate_target) - longint'(v.rate_r));
        // down to q.16, floor
        mx = mx >>> 3;
        my = my >>> 3;
        mz = mz >>> 3;
        // reciprocal products back to q.16, floor
        tx = (mx * longint'(gains.arm_rcp)) >>> 8;
        ty = (my * longint'(gains.arm_rcp)) >>> 8;
        tz = (mz * longint'(gains.yaw_rcp)) >>> 8;
        tt = longint'(v.thrust_target) * longint'(gains.thrust_rcp);
        // x-quad mixer
        c.rotor[0] = rotor_speed(tt - tx - ty - tz);
        c.rotor[1] = rotor_speed(tt + tx - ty + tz);
        c.rotor[2] = rotor_speed(tt + tx + ty - tz);
        c.rotor[3] = rotor_speed(tt - tx + ty + tz);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // result checker: every output beat against the oldest prediction
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_rotor_cmd       exp_cmd;
        qapm_pkg::t_speed got [qapm_pkg::NumRotors];
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got[0] = out_if.rotor0_speed;
            got[1] = out_if.rotor1_speed;
            got[2] = out_if.rotor2_speed;
            got[3] = out_if.rotor3_speed;
            if (pending_cmds.size() == 0) begin
                n_fail = n_fail + 1;
                if (n_fail <= ReportCap)
                    $error("rotor command beat with no vehicle beat outstanding");
            end else begin
                exp_cmd = pending_cmds.pop_front();
                for (int r = 0; r < qapm_pkg::NumRotors; r++) begin
                    if (got[r] !== exp_cmd.rotor[r]) begin
                        n_fail = n_fail + 1;
                        // keep the log readable when everything is off
                        if (n_fail <= ReportCap)
                            $error("rotor%0d_speed: expected %0d, got %0d",
                                   r, exp_cmd.rotor[r], got[r]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: long hold-off first, then the ready pattern of the phase
    // ------------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            out_if.ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            case (rx_mode)
                RxAlways: begin
                    out_if.ready <= 1'b1;
                end
                RxRandom: begin
                    out_if.ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    out_if.ready <= rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic [qapm_pkg::CfgIndexW-1:0] idx,
                             input logic [qapm_pkg::CfgDataW-1:0]  data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        // narrow registers keep the low half, unknown indexes do nothing
        case (idx)
            qapm_pkg::RegRollPropGain:   gains.roll_prop   = data[15:0];
            qapm_pkg::RegPitchPropGain:  gains.pitch_prop  = data[15:0];
            qapm_pkg::RegRollDerivGain:  gains.roll_deriv  = data[15:0];
            qapm_pkg::RegPitchDerivGain: gains.pitch_deriv = data[15:0];
            qapm_pkg::RegYawRateGain:    gains.yaw_rate    = data[15:0];
            qapm_pkg::RegThrustCoefRcp:  gains.thrust_rcp  = data;
            qapm_pkg::RegArmMomentRcp:   gains.arm_rcp     = data;
            qapm_pkg::RegYawMomentRcp:   gains.yaw_rcp     = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] upper_fill(input bit junk);
        return junk ? 16'($urandom) : 16'h0000;
    endfunction

    task automatic load_gains(input t_gains g, input bit junk);
        write_reg(qapm_pkg::RegRollPropGain,   {upper_fill(junk), g.roll_prop});
        write_reg(qapm_pkg::RegPitchPropGain,  {upper_fill(junk), g.pitch_prop});
        write_reg(qapm_pkg::RegRollDerivGain,  {upper_fill(junk), g.roll_deriv});
        write_reg(qapm_pkg::RegPitchDerivGain, {upper_fill(junk), g.pitch_deriv});
        write_reg(qapm_pkg::RegYawRateGain,    {upper_fill(junk), g.yaw_rate});
        write_reg(qapm_pkg::RegThrustCoefRcp,  g.thrust_rcp);
        write_reg(qapm_pkg::RegArmMomentRcp,   g.arm_rcp);
        write_reg(qapm_pkg::RegYawMomentRcp,   g.yaw_rcp);
    endtask

    // offer one beat and hold it until taken; valid stays high on return
    task automatic send_vehicle(input t_vehicle v);
        in_if.valid           <= 1'b1;
        in_if.yaw_rate_target <= v.yaw_rate_target;
        in_if.roll_target     <= v.roll_target;
        in_if.pitch_target    <= v.pitch_target;
        in_if.thrust_target   <= v.thrust_target;
        in_if.roll_meas       <= v.roll_meas;
        in_if.pitch_meas      <= v.pitch_meas;
        in_if.rate_p          <= v.rate_p;
        in_if.rate_q          <= v.rate_q;
        in_if.rate_r          <= v.rate_r;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        pending_cmds.push_back(predict_rotor_cmd(v));
        @(negedge i_clk);
    endtask

    task automatic idle(input int n);
        in_if.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // stop sending, wait for every prediction to be matched, let the pipe empty
    task automatic settle();
        idle(1);
        while (pending_cmds.size() != 0)
            @(negedge i_clk);
        repeat (2 * qapm_pkg::NumStages) @(negedge i_clk);
    endtask

    function automatic t_vehicle make_vehicle(
        input logic [15:0] yaw_t, roll_t, pitch_t, thrust_t,
        input logic [15:0] roll_m, pitch_m, p, q, r
    );
        t_vehicle v;
        v.yaw_rate_target = yaw_t;
        v.roll_target     = roll_t;
        v.pitch_target    = pitch_t;
        v.thrust_target   = thrust_t;
        v.roll_meas       = roll_m;
        v.pitch_meas      = pitch_m;
        v.rate_p          = p;
        v.rate_q          = q;
        v.rate_r          = r;
        return v;
    endfunction

    // full-range word with extra weight on the corners
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // half flight-like (small angles and rates, moderate thrust), half anything
    function automatic t_vehicle random_vehicle();
        if ($urandom_range(0, 1) == 0)
            return make_vehicle(16'($urandom_range(0, 16383)) - 16'd8192,
                                16'($urandom_range(0, 4095)) - 16'd2048,
                                16'($urandom_range(0, 4095)) - 16'd2048,
                                16'($urandom_range(0, 8191)),
                                16'($urandom_range(0, 4095)) - 16'd2048,
                                16'($urandom_range(0, 4095)) - 16'd2048,
                                16'($urandom_range(0, 16383)) - 16'd8192,
                                16'($urandom_range(0, 16383)) - 16'd8192,
                                16'($urandom_range(0, 16383)) - 16'd8192);
        return make_vehicle(rand_word(), rand_word(), rand_word(), rand_word(),
                            rand_word(), rand_word(), rand_word(), rand_word(),
                            rand_word());
    endfunction

    // 0 near the defaults, 1 everything at max, 2 anything, 3 everything zero
    function automatic t_gains random_gains(input int kind);
        t_gains g;
        case (kind)
            0: begin
                g.roll_prop   = 16'($urandom_range(0, 1024));
                g.pitch_prop  = 16'($urandom_range(0, 1024));
                g.roll_deriv  = 16'($urandom_range(0, 512));
                g.pitch_deriv = 16'($urandom_range(0, 512));
                g.yaw_rate    = 16'($urandom_range(0, 512));
                g.thrust_rcp  = 32'($urandom_range(1 << 20, 1 << 28));
                g.arm_rcp     = 32'($urandom_range(1 << 20, 1 << 28));
                g.yaw_rcp     = 32'($urandom_range(1 << 20, 1 << 29));
            end
            1: begin
                g = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            end
            2: begin
                g = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), $urandom, $urandom, $urandom};
            end
            default: begin
                g = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0};
            end
        endcase
        return g;
    endfunction

    // bursts of random length with random gaps unless gapless; one drain pause midway
    task automatic run_traffic(input int n, input bit gapless);
        int burst_left;
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) begin
            send_vehicle(random_vehicle());
            burst_left = burst_left - 1;
            if (i == n / 2) begin
                settle();
            end else if (burst_left == 0 && !gapless) begin
                idle($urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values of every register, field extremes, negative mixes
    task automatic test_reset_defaults();
        rx_mode = RxRandom;
        send_vehicle(make_vehicle(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                  16'h0000, 16'h0000, 16'h0000, 16'h0000));
        // pure hover, all four rotors equal
        send_vehicle(make_vehicle(16'h0000, 16'h0000, 16'h0000, 16'h0A00, 16'h0000,
                                  16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_vehicle(make_vehicle(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF,
                                  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_vehicle(make_vehicle(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h8000,
                                  16'h8000, 16'h8000, 16'h8000, 16'h8000));
        // largest negative roll error on little thrust drives two mixes below zero
        send_vehicle(make_vehicle(16'h0000, 16'h8000, 16'h0000, 16'h0100, 16'h7FFF,
                                  16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_vehicle(make_vehicle(16'h0000, 16'h0000, 16'h7FFF, 16'h1000, 16'h0000,
                                  16'h8000, 16'h8000, 16'h8000, 16'h0000));
        // largest yaw rate error
        send_vehicle(make_vehicle(16'h7FFF, 16'h0000, 16'h0000, 16'h2000, 16'h0000,
                                  16'h0000, 16'h0000, 16'h0000, 16'h8000));
        send_vehicle(make_vehicle(16'h8000, 16'h0000, 16'h0000, 16'h0800, 16'h0000,
                                  16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        settle();
    endtask

    // each register by its own index, then writes to indexes past the map
    task automatic test_register_map();
        write_reg(qapm_pkg::RegRollPropGain,   32'd300);
        write_reg(qapm_pkg::RegPitchPropGain,  32'd200);
        write_reg(qapm_pkg::RegRollDerivGain,  32'd10);
        write_reg(qapm_pkg::RegPitchDerivGain, 32'd90);
        write_reg(qapm_pkg::RegYawRateGain,    32'd500);
        write_reg(qapm_pkg::RegThrustCoefRcp,  32'd20000000);
        write_reg(qapm_pkg::RegArmMomentRcp,   32'd30000000);
        write_reg(qapm_pkg::RegYawMomentRcp,   32'd100000000);
        for (int k = NumRegs; k < (1 << qapm_pkg::CfgIndexW); k++)
            write_reg(qapm_pkg::CfgIndexW'(k), $urandom);
        send_vehicle(make_vehicle(16'h0200, 16'h0100, 16'hFF00, 16'h0C00, 16'hFFC0,
                                  16'h0040, 16'h0300, 16'hFD00, 16'hFF80));
        send_vehicle(make_vehicle(16'hFE00, 16'hFF00, 16'h0100, 16'h0600, 16'h0040,
                                  16'hFFC0, 16'hFD00, 16'h0300, 16'h0080));
        send_vehicle(make_vehicle(16'h0000, 16'h0000, 16'h0000, 16'h0400, 16'h0000,
                                  16'h0000, 16'h0000, 16'h0000, 16'h0000));
        settle();
    endtask

    // every gain and reciprocal at max: speeds pinned at the top of q12.4, or at zero for negative mixes
    task automatic test_saturation();
        rx_mode = RxAlways;
        load_gains(random_gains(1), 1'b0);
        send_vehicle(make_vehicle(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
                                  16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_vehicle(make_vehicle(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000,
                                  16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_vehicle(make_vehicle(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF,
                                  16'h8000, 16'h7FFF, 16'h8000, 16'h8000));
        settle();
    endtask

    // zero reciprocals drop their terms
    task automatic test_zero_coefficients();
        t_gains g;
        g = random_gains(1);
        g.thrust_rcp = '0;
        g.arm_rcp    = '0;
        g.yaw_rcp    = '0;
        load_gains(g, 1'b0);
        send_vehicle(make_vehicle(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h8000,
                                  16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_vehicle(make_vehicle(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
                                  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        // register writes only with the pipe empty
        settle();
        // thrust alone: moments present but their reciprocals are zero
        write_reg(qapm_pkg::RegThrustCoefRcp, qapm_pkg::RstThrustCoefRcp);
        send_vehicle(make_vehicle(16'h7FFF, 16'h8000, 16'h7FFF, 16'h3000, 16'h7FFF,
                                  16'h8000, 16'h7FFF, 16'h8000, 16'h8000));
        settle();
    endtask

    // receiver holds off long enough for the pipe to fill and push back
    task automatic test_backpressure();
        load_gains(reset_gains(), 1'b0);
        rx_mode = RxAlways;
        rx_hold = HoldOff;
        repeat (60) send_vehicle(random_vehicle());
        settle();
    endtask

    // random beats over several register settings and receiver behaviors
    task automatic test_random_traffic();
        int kinds [NumPhases];
        kinds = '{0, 1, 0, 3, 2, 0};
        for (int ph = 0; ph < NumPhases; ph++) begin
            // upper data bits on the narrow registers in one phase
            load_gains(random_gains(kinds[ph]), ph == 4);
            rx_mode    = t_rx_mode'(ph % 3);
            rx_pattern = 16'($urandom) | 16'h0001;
            run_traffic(RandomItems / NumPhases, ph == 2);
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n               = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        in_if.valid           = 1'b0;
        in_if.yaw_rate_target = '0;
        in_if.roll_target     = '0;
        in_if.pitch_target    = '0;
        in_if.thrust_target   = '0;
        in_if.roll_meas       = '0;
        in_if.pitch_meas      = '0;
        in_if.rate_p          = '0;
        in_if.rate_q          = '0;
        in_if.rate_r          = '0;
        out_if.ready          = 1'b0;
        gains                 = reset_gains();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_register_map();
        test_saturation();
        test_zero_coefficients();
        test_backpressure();
        test_random_traffic();

        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
